/* rtl/core/rse_pkg.sv */
package rse_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int LFSR_W       = 16;
	localparam int VALUE_W      = 32;
	localparam int COUNT_OUT_W  = 7;

	localparam logic [LFSR_W-1:0] SEED_RESET = 16'hACE1;
	localparam logic [LFSR_W-1:0] LFSR_TAPS  = 16'hB400;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_SAMPLE = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_MISS  = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef struct packed {
		op_t                       operation;
		logic signed [VALUE_W-1:0] value;
	} rse_cmd_t;

	typedef struct packed {
		status_t                   status;
		logic signed [VALUE_W-1:0] sample_value;
		logic [COUNT_OUT_W-1:0]    member_count;
	} rse_result_t;

	// queued work between front and back
	typedef struct packed {
		op_t                kind;
		logic [VALUE_W-1:0] value;
	} rse_item_t;

	function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] s);
		logic [LFSR_W-1:0] n;
		n = {1'b0, s[LFSR_W-1:1]};
		if (s[0]) begin
			n = n ^ LFSR_TAPS;
		end
		return n;
	endfunction

	function automatic logic [LFSR_W-1:0] seed_load(input logic [LFSR_W-1:0] seed);
		return (seed == '0) ? LFSR_W'(1) : seed;
	endfunction

endpackage

/* rtl/core/rse_front.sv */
module rse_front
	import rse_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  rse_cmd_t  cmd,
	output logic      q_valid,
	output rse_item_t q_item,
	input  logic      q_pop
);

	localparam int QD = 2;
	localparam int PW = $clog2(QD);
	localparam int FW = $clog2(QD + 1);

	rse_item_t       entry_q [QD];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [FW-1:0]   fill_q;
	rse_item_t       item_d;
	logic            push;

	// classify the incoming beat; the value is only carried for insert and remove
	always_comb begin
		item_d.kind  = cmd.operation;
		item_d.value = cmd.value;
		unique case (cmd.operation) inside
			OP_INSERT, OP_REMOVE: item_d.value = cmd.value;
			OP_SAMPLE, OP_NONE:   item_d.value = '0;
			default:              item_d.value = '0;
		endcase
	end

	assign busy    = (fill_q == FW'(QD));
	assign push    = start && !busy;
	assign q_valid = (fill_q != '0);
	assign q_item  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= item_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QD - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (q_pop && q_valid) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QD - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !(q_pop && q_valid)) begin
				fill_q <= fill_q + FW'(1);
			end else if (!push && q_pop && q_valid) begin
				fill_q <= fill_q - FW'(1);
			end
		end
	end

endmodule

/* rtl/core/rse_mod.sv */
module rse_mod
	import rse_pkg::*;
#(
	parameter int DW = 7
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [LFSR_W-1:0] dividend,
	input  logic [DW-1:0]     divisor,
	output logic              done,
	output logic [DW-1:0]     rem
);

	localparam int CNTW = $clog2(LFSR_W + 1);

	logic [LFSR_W-1:0] dvd_q;
	logic [DW-1:0]     dsr_q;
	logic [DW-1:0]     rem_q;
	logic [CNTW-1:0]   cnt_q;
	logic              run_q;
	logic              done_q;
	logic [DW:0]       trial;
	logic [DW:0]       diff;

	// restoring remainder, one dividend bit per cycle
	assign trial = {rem_q, dvd_q[LFSR_W-1]};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[LFSR_W-2:0], 1'b0};
			rem_q <= (trial >= {1'b0, dsr_q}) ? diff[DW-1:0] : trial[DW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNTW'(LFSR_W);
				run_q <= 1'b1;
			end else if (run_q) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

/* rtl/core/rse_back.sv */
module rse_back
	import rse_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  rse_item_t         q_item,
	output logic              q_pop,
	input  logic              cfg_we,
	input  logic [LFSR_W-1:0] cfg_wdata,
	output logic              done,
	output rse_result_t       result
);

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_SCAN = 5'b00010,
		S_MOVE = 5'b00100,
		S_DIV  = 5'b01000,
		S_PICK = 5'b10000
	} state_t;

	logic [VALUE_W-1:0] mem [CAPACITY];
	logic [VALUE_W-1:0] rdata_q;

	state_t            state_q, state_d;
	rse_item_t         item_q;
	logic [CW-1:0]     count_q, count_d;
	logic [LFSR_W-1:0] lfsr_q, lfsr_d;
	logic [CW-1:0]     ptr_q;
	logic              cmp_vld_s1;
	logic [IW-1:0]     cmp_idx_s1;
	logic [IW-1:0]     slot_q;
	logic              done_q;
	rse_result_t       res_q;

	logic [CW-1:0]      cnt_m1;
	logic [IW-1:0]      last_idx;
	logic               hit;
	logic               at_last;
	logic [IW-1:0]      raddr;
	logic               we;
	logic [IW-1:0]      waddr;
	logic [VALUE_W-1:0] wdata;
	logic               emit;
	status_t            emit_status;
	logic [VALUE_W-1:0] emit_sample;
	logic               div_start;
	logic               div_done;
	logic [CW-1:0]      div_rem;
	logic               scan_go;

	rse_mod #(.DW(CW)) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (lfsr_d),
		.divisor  (count_q),
		.done     (div_done),
		.rem      (div_rem)
	);

	assign cnt_m1   = count_q - CW'(1);
	assign last_idx = cnt_m1[IW-1:0];
	assign hit      = cmp_vld_s1 && (rdata_q == item_q.value);
	assign at_last  = cmp_vld_s1 && (cmp_idx_s1 == last_idx);

	// read address: scan pointer, or the last entry once the scan hits, or the sample slot
	always_comb begin
		raddr = ptr_q[IW-1:0];
		if (state_q == S_SCAN && hit) begin
			raddr = last_idx;
		end else if (state_q == S_DIV && div_done) begin
			raddr = div_rem[IW-1:0];
		end
	end

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		lfsr_d      = lfsr_q;
		q_pop       = 1'b0;
		we          = 1'b0;
		waddr       = count_q[IW-1:0];
		wdata       = item_q.value;
		emit        = 1'b0;
		emit_status = ST_DONE;
		emit_sample = '0;
		div_start   = 1'b0;
		scan_go     = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					unique case (q_item.kind)
						OP_INSERT: begin
							if (count_q == '0) begin
								we      = 1'b1;
								waddr   = '0;
								wdata   = q_item.value;
								count_d = CW'(1);
								emit    = 1'b1;
							end else begin
								scan_go = 1'b1;
								state_d = S_SCAN;
							end
						end
						OP_REMOVE: begin
							if (count_q == '0) begin
								emit        = 1'b1;
								emit_status = ST_MISS;
							end else begin
								scan_go = 1'b1;
								state_d = S_SCAN;
							end
						end
						OP_SAMPLE: begin
							lfsr_d = lfsr_next(lfsr_q);
							if (count_q == '0) begin
								emit        = 1'b1;
								emit_status = ST_EMPTY;
							end else begin
								div_start = 1'b1;
								state_d   = S_DIV;
							end
						end
						default: begin
							emit = 1'b1;
						end
					endcase
				end
			end
			S_SCAN: begin
				if (hit) begin
					if (item_q.kind == OP_INSERT) begin
						emit        = 1'b1;
						emit_status = ST_MISS;
						state_d     = S_IDLE;
					end else begin
						state_d = S_MOVE;
					end
				end else if (at_last) begin
					state_d = S_IDLE;
					emit    = 1'b1;
					if (item_q.kind == OP_REMOVE) begin
						emit_status = ST_MISS;
					end else if (count_q >= CW'(CAPACITY)) begin
						emit_status = ST_FULL;
					end else begin
						we      = 1'b1;
						count_d = count_q + CW'(1);
					end
				end
			end
			S_MOVE: begin
				// last entry fills the hole left by the removed one
				we      = 1'b1;
				waddr   = slot_q;
				wdata   = rdata_q;
				count_d = cnt_m1;
				emit    = 1'b1;
				state_d = S_IDLE;
			end
			S_DIV: begin
				if (div_done) begin
					state_d = S_PICK;
				end
			end
			S_PICK: begin
				emit        = 1'b1;
				emit_sample = rdata_q;
				state_d     = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		if (cfg_we) begin
			lfsr_d = seed_load(cfg_wdata);
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_item;
		end
		if (state_q == S_SCAN && hit) begin
			slot_q <= cmp_idx_s1;
		end
		if (emit) begin
			res_q.status       <= emit_status;
			res_q.sample_value <= emit_sample;
			res_q.member_count <= COUNT_OUT_W'(count_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			lfsr_q     <= SEED_RESET;
			ptr_q      <= '0;
			cmp_vld_s1 <= 1'b0;
			cmp_idx_s1 <= '0;
			done_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			lfsr_q  <= lfsr_d;
			done_q  <= emit;
			if (scan_go) begin
				ptr_q      <= '0;
				cmp_vld_s1 <= 1'b0;
			end else if (state_q == S_SCAN && ptr_q < count_q) begin
				ptr_q      <= ptr_q + CW'(1);
				cmp_vld_s1 <= 1'b1;
				cmp_idx_s1 <= ptr_q[IW-1:0];
			end else begin
				cmp_vld_s1 <= 1'b0;
			end
		end
	end

	assign done   = done_q;
	assign result = res_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("member count above capacity");

	a_fail_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && res_q.status != ST_DONE |-> count_q == $past(count_q))
		else $error("failed operation changed the member count");

	a_sample_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && res_q.sample_value != '0 |-> res_q.status == ST_DONE)
		else $error("sample value on a failed result");

	a_rem_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV && div_done |-> div_rem < count_q)
		else $error("sample index beyond member count");
`endif

endmodule

/* rtl/core/randomized_set_engine.sv */
// randomized set engine: a set of distinct 32-bit values with insert, remove and
// random sample.
// command channel: a beat is taken at a clock edge where start is high and busy
// is low; cmd carries the operation and value. a two-entry queue sits between
// the command front and the executing back, so busy rises only when both slots
// are taken. a beat taken while the back is idle is popped by it at the next edge.
// result channel: done is high for one cycle with result; there is no stall,
// the receiver must take every beat. one result per command, in command order.
// steps, from the back taking a beat off the queue to its done cycle: a no-op or a
// trivial case (empty set) finishes straight from idle; insert scans the store
// one entry per cycle through the single read port; remove likewise, plus a
// move of the last entry into the hole; sample runs a 16-step bit-serial
// remainder of the lfsr by the count, then a store read. the back takes the
// next beat off the queue at the edge that ends its done cycle.
// seed port: cfg_we/cfg_wdata load the lfsr at once (zero loads 1); write it
// only while the engine is idle.
// reset empties the set and loads the lfsr with the default seed; store
// contents are not cleared, only entries below the count are ever used.
module randomized_set_engine
	import rse_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  rse_cmd_t          cmd,
	input  logic              cfg_we,
	input  logic [LFSR_W-1:0] cfg_wdata,
	output logic              done,
	output rse_result_t       result
);

	logic      q_valid;
	logic      q_pop;
	rse_item_t q_item;

	rse_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.cmd     (cmd),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	rse_back #(.CAPACITY(CAPACITY)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.done      (done),
		.result    (result)
	);

endmodule

/* tb/randomized_set_engine_tb.sv */
`timescale 1ns / 100ps

module randomized_set_engine_tb;
	import rse_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 125;

	typedef enum int {
		PROFILE_FILL,
		PROFILE_CHURN,
		PROFILE_DRAIN
	} profile_t;

	// mirror of the set: store, count and sampling lfsr, plus the replies still owed
	class set_mirror;
		logic [VALUE_W-1:0] slots [CAPACITY_DEF];
		int                 total;
		logic [LFSR_W-1:0]  lfsr;
		rse_result_t        owed_replies [$];
		int                 errors;
		int                 commands;
		int                 checked;
		int                 full_hits;
		int                 empty_hits;
		int                 miss_hits;

		function new();
			total      = 0;
			lfsr       = SEED_RESET;
			errors     = 0;
			commands   = 0;
			checked    = 0;
			full_hits  = 0;
			empty_hits = 0;
			miss_hits  = 0;
		endfunction

		function void load_seed(input logic [LFSR_W-1:0] seed);
			// an all-zero seed would lock the lfsr
			lfsr = (seed == '0) ? LFSR_W'(1) : seed;
		endfunction

		function int slot_of(input logic [VALUE_W-1:0] v);
			for (int i = 0; i < total; i++) begin
				if (slots[i] == v) begin
					return i;
				end
			end
			return -1;
		endfunction

		function void record_command(input rse_cmd_t c);
			rse_result_t r;
			int          slot;
			r.status       = ST_DONE;
			r.sample_value = '0;
			commands++;
			case (c.operation)
				OP_INSERT: begin
					slot = slot_of(c.value);
					if (slot >= 0) begin
						r.status = ST_MISS;
					end else if (total >= CAPACITY_DEF) begin
						r.status = ST_FULL;
					end else begin
						slots[total] = c.value;
						total++;
					end
				end
				OP_REMOVE: begin
					slot = slot_of(c.value);
					if (slot < 0) begin
						r.status = ST_MISS;
					end else begin
						// last entry fills the hole
						slots[slot] = slots[total-1];
						total--;
					end
				end
				OP_SAMPLE: begin
					lfsr = {1'b0, lfsr[LFSR_W-1:1]} ^ (lfsr[0] ? LFSR_TAPS : '0);
					if (total == 0) begin
						r.status = ST_EMPTY;
					end else begin
						r.sample_value = slots[int'(lfsr) % total];
					end
				end
				default: begin
				end
			endcase
			r.member_count = COUNT_OUT_W'(total);
			case (r.status)
				ST_FULL:  full_hits++;
				ST_EMPTY: empty_hits++;
				ST_MISS:  miss_hits++;
				default: begin
				end
			endcase
			owed_replies.push_back(r);
		endfunction

		function void check_reply(input rse_result_t got);
			rse_result_t want;
			if (owed_replies.size() == 0) begin
				errors++;
				$display("%0t: unexpected result beat status %0d sample %h count %0d", $time,
					got.status, got.sample_value, got.member_count);
				return;
			end
			want = owed_replies.pop_front();
			checked++;
			if (got.status !== want.status) begin
				errors++;
				$display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
			end
			if (got.sample_value !== want.sample_value) begin
				errors++;
				$display("%0t: sample_value expected %h actual %h", $time,
					want.sample_value, got.sample_value);
			end
			if (got.member_count !== want.member_count) begin
				errors++;
				$display("%0t: member_count expected %0d actual %0d", $time,
					want.member_count, got.member_count);
			end
		endfunction
	endclass

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              start     = 1'b0;
	logic              busy;
	rse_cmd_t          cmd       = '0;
	logic              cfg_we    = 1'b0;
	logic [LFSR_W-1:0] cfg_wdata = '0;
	logic              done;
	rse_result_t       result;

	set_mirror mirror = new();
	int        cycles = 0;
	int        seeds_used = 0;

	randomized_set_engine dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.done     (done),
		.result   (result)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still owed", cycles,
				mirror.owed_replies.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			mirror.check_reply(result);
		end
	end

	// holds start until the beat is taken
	task automatic send_cmd(input op_t op, input logic [VALUE_W-1:0] v);
		@(negedge clk);
		start <= 1'b1;
		cmd   <= '{operation: op, value: v};
		do begin
			@(posedge clk);
		end while (busy);
		mirror.record_command('{operation: op, value: v});
	endtask

	task automatic pause(input int n);
		@(negedge clk);
		start <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic wait_drain();
		@(negedge clk);
		start <= 1'b0;
		while (mirror.owed_replies.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_seed(input logic [LFSR_W-1:0] seed);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= seed;
		@(posedge clk);
		mirror.load_seed(seed);
		@(negedge clk);
		cfg_we <= 1'b0;
		seeds_used++;
	endtask

	task automatic run_phase(input profile_t profile, input bit with_gaps);
		logic [VALUE_W-1:0] pool [96];
		int                 pool_n;
		int                 ins_pct;
		int                 rem_pct;
		int                 sent;
		int                 burst;
		int                 pick;
		logic [VALUE_W-1:0] v;
		case (profile)
			PROFILE_FILL: begin
				pool_n  = 96;
				ins_pct = 75;
				rem_pct = 8;
			end
			PROFILE_CHURN: begin
				pool_n  = 40;
				ins_pct = 40;
				rem_pct = 32;
			end
			default: begin
				pool_n  = 40;
				ins_pct = 18;
				rem_pct = 52;
			end
		endcase
		for (int i = 0; i < pool_n; i++) begin
			pool[i] = $urandom;
		end
		pool[0] = 32'h8000_0000;
		pool[1] = 32'h7FFF_FFFF;
		sent = 0;
		while (sent < PHASE_ITEMS) begin
			burst = $urandom_range(1, 24);
			for (int b = 0; b < burst; b++) begin
				pick = $urandom_range(0, 99);
				if (pick < 4) begin
					send_cmd(OP_NONE, $urandom);
				end else if (pick < 4 + ins_pct) begin
					send_cmd(OP_INSERT, pool[$urandom_range(0, pool_n - 1)]);
					sent++;
				end else if (pick < 4 + ins_pct + rem_pct) begin
					if (mirror.total > 0 && $urandom_range(0, 9) < 7) begin
						v = mirror.slots[$urandom_range(0, mirror.total - 1)];
					end else if ($urandom_range(0, 3) == 0) begin
						v = $urandom;
					end else begin
						v = pool[$urandom_range(0, pool_n - 1)];
					end
					send_cmd(OP_REMOVE, v);
					sent++;
				end else begin
					// value field is ignored on sample, keep it random anyway
					send_cmd(OP_SAMPLE, $urandom);
					sent++;
				end
			end
			if (with_gaps && $urandom_range(0, 3) != 0) begin
				pause($urandom_range(1, 8));
			end
		end
	endtask

	initial begin
		logic [LFSR_W-1:0] seed;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (3) @(negedge clk);

		// directed: empty set cases, extremes, duplicates, move-last removal
		send_cmd(OP_SAMPLE, 32'h0000_0000);
		send_cmd(OP_REMOVE, 32'h0000_0005);
		send_cmd(OP_NONE,   32'hFFFF_FFFF);
		send_cmd(OP_INSERT, 32'h8000_0000);
		send_cmd(OP_INSERT, 32'h7FFF_FFFF);
		send_cmd(OP_INSERT, 32'h0000_0000);
		send_cmd(OP_INSERT, 32'hFFFF_FFFF);
		send_cmd(OP_INSERT, 32'h8000_0000);
		send_cmd(OP_REMOVE, 32'h0000_3039);
		send_cmd(OP_SAMPLE, 32'hFFFF_FFFF);
		send_cmd(OP_SAMPLE, 32'h0000_0000);
		send_cmd(OP_SAMPLE, 32'h1234_5678);
		send_cmd(OP_REMOVE, 32'h8000_0000);
		send_cmd(OP_SAMPLE, 32'h0000_0000);
		send_cmd(OP_REMOVE, 32'hFFFF_FFFF);
		send_cmd(OP_NONE,   32'h0000_0000);
		send_cmd(OP_INSERT, 32'h5555_5555);
		send_cmd(OP_INSERT, 32'hAAAA_AAAA);
		send_cmd(OP_SAMPLE, 32'h0000_0000);
		send_cmd(OP_REMOVE, 32'h0000_0000);
		send_cmd(OP_REMOVE, 32'h7FFF_FFFF);
		send_cmd(OP_REMOVE, 32'h5555_5555);
		send_cmd(OP_REMOVE, 32'hAAAA_AAAA);
		send_cmd(OP_SAMPLE, 32'h0000_0000);

		// random phases, each after a fresh seed write
		for (int phase = 0; phase < 6; phase++) begin
			wait_drain();
			case (phase)
				0: seed = '0;
				1: seed = '1;
				2: seed = LFSR_W'(1);
				default: seed = LFSR_W'($urandom_range(1, 65535));
			endcase
			write_seed(seed);
			run_phase(profile_t'(phase % 3), phase != 3);
		end

		wait_drain();
		repeat (80) @(posedge clk);
		if (mirror.owed_replies.size() != 0) begin
			mirror.errors++;
			$display("%0t: %0d expected results never arrived", $time,
				mirror.owed_replies.size());
		end
		$display("ran %0d commands under %0d seed writes, %0d results checked",
			mirror.commands, seeds_used, mirror.checked);
		$display("saw %0d full inserts, %0d empty samples, %0d present/absent misses",
			mirror.full_hits, mirror.empty_hits, mirror.miss_hits);
		if (mirror.errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

/* sim.f */
rtl/core/rse_pkg.sv
rtl/core/rse_front.sv
rtl/core/rse_mod.sv
rtl/core/rse_back.sv
rtl/core/randomized_set_engine.sv
tb/randomized_set_engine_tb.sv
